/* rtl/core/qttp_pkg.sv */
// Package with shared types, field widths and codes of the quality tail trim point unit.
package qttp_pkg;

  // Default depth of the recent-score ring.
  localparam int unsigned RunDepthDef = 256;

  // Longest read whose position is still counted; the position holds beyond it.
  localparam int unsigned MaxReadLen = 65535;
  localparam int unsigned ReadCap    = (MaxReadLen < 65535) ? MaxReadLen : 65535;

  // Field widths.
  localparam int unsigned OpW    = 2;
  localparam int unsigned SymW   = 8;
  localparam int unsigned ScoreW = 8;
  localparam int unsigned ThrW   = 9;
  localparam int unsigned PosW   = 16;
  localparam int unsigned SumW   = 16;

  // Request opcodes.
  localparam logic [OpW-1:0] OpWrite  = 2'd0;
  localparam logic [OpW-1:0] OpSymbol = 2'd1;
  localparam logic [OpW-1:0] OpEmpty  = 2'd2;

  // Configuration register indexes and reset values.
  localparam int unsigned     CfgIdxW       = 2;
  localparam logic [CfgIdxW-1:0] RegThreshold  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSuccessive = 2'd1;
  localparam logic [ThrW-1:0] ThrReset      = 9'd1;

  // Depth of the result queue at the output.
  localparam int unsigned ResQDepth = 4;

  // One input request.
  typedef struct packed {
    logic [OpW-1:0]    opcode;
    logic [SymW-1:0]   symbol;
    logic [ScoreW-1:0] score;
    logic              last_symbol;
  } qttp_in_t;

  // One result, issued once per finished read.
  typedef struct packed {
    logic [PosW-1:0] trim_end;
    logic            threshold_hit;
  } qttp_out_t;

endpackage

/* rtl/core/quality_tail_trim_point_unit.sv */
// Top level of the quality tail trim point unit.
// The unit takes these requests: score table writes, quality symbols and
// empty-read markers. Each symbol is scored through the 256-entry score table and
// summed either over the whole read or over a window of the last threshold scores
// held in a RUN_DEPTH-slot ring memory; at the end of each read one result gives the
// number of leading symbols to keep. The table and ring slot are read in the first
// stage, and the sum, compare and ring write-back happen in the second. Results wait
// in a four-entry queue; requests are refused only while three or more results are
// waiting, so with the output taking results the rate is one request per clock. The
// ring is cleared at read end by a fill count, so no clearing pass is run after
// reset. Score table entries must be written before use.
module quality_tail_trim_point_unit #(
  parameter int unsigned RUN_DEPTH = qttp_pkg::RunDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [qttp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [qttp_pkg::ThrW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  qttp_pkg::qttp_in_t            in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output qttp_pkg::qttp_out_t           out_rsp_o
);
  import qttp_pkg::*;

  logic [ThrW-1:0]   threshold_q;
  logic              successive_q;
  logic              accept;
  logic              tbl_we;
  logic              tbl_re;
  logic [ScoreW-1:0] tbl_score;
  logic              res_valid;
  qttp_out_t         res;
  logic              q_room;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= ThrReset;
      successive_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegThreshold: begin
          threshold_q <= cfg_data_i;
        end
        RegSuccessive: begin
          successive_q <= cfg_data_i[0];
        end
        default: begin
          threshold_q <= threshold_q;
        end
      endcase
    end
  end

  // Request acceptance is paced by the room left in the result queue.
  assign in_ready_o = q_room;
  assign accept     = in_valid_i && in_ready_o;

  // Score table access in the first stage.
  assign tbl_we = accept && (in_req_i.opcode == OpWrite);
  assign tbl_re = accept && (in_req_i.opcode == OpSymbol);

  qttp_score_table u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .re_i    (tbl_re),
    .addr_i  (in_req_i.symbol),
    .wdata_i (in_req_i.score),
    .rdata_o (tbl_score)
  );

  qttp_trim_core #(
    .RUN_DEPTH (RUN_DEPTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_i        (in_req_i),
    .threshold_i  (threshold_q),
    .successive_i (successive_q),
    .score_i      (tbl_score),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  qttp_res_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .data_i      (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_rsp_o),
    .room_o      (q_room)
  );

endmodule

/* rtl/core/qttp_score_table.sv */
// Score table: 256-entry synchronous memory that maps a quality symbol to its score.
module qttp_score_table (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic                       re_i,
  input  logic [qttp_pkg::SymW-1:0]   addr_i,
  input  logic [qttp_pkg::ScoreW-1:0] wdata_i,
  output logic [qttp_pkg::ScoreW-1:0] rdata_o
);
  import qttp_pkg::*;

  localparam int unsigned Depth = 1 << SymW;

  logic [ScoreW-1:0] mem_q [Depth];
  logic [ScoreW-1:0] rdata_q;

  // One write and one registered read per cycle; entries have no reset.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/qttp_trim_core.sv */
// Trim core: recent-score ring memory, read pointer, and the sum and compare stage.
module qttp_trim_core #(
  parameter int unsigned RUN_DEPTH = qttp_pkg::RunDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  qttp_pkg::qttp_in_t          req_i,
  input  logic [qttp_pkg::ThrW-1:0]   threshold_i,
  input  logic                       successive_i,
  input  logic [qttp_pkg::ScoreW-1:0] score_i,
  output logic                       res_valid_o,
  output qttp_pkg::qttp_out_t         res_o
);
  import qttp_pkg::*;

  localparam int unsigned PtrW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(RUN_DEPTH + 1);
  localparam int unsigned CmpW = (CntW > ThrW) ? CntW : ThrW;
  localparam int unsigned CutW = PosW + 1;

  // Ring memory and its registered read port.
  logic [ScoreW-1:0] ring_mem_q [RUN_DEPTH];
  logic [ScoreW-1:0] ring_rdata_q;
  logic              ring_re;
  logic              ring_we;

  // Ring pointer and fill count; slots at or above the fill count read as zero.
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] fill_q, fill_d;

  // Second stage registers.
  logic            s1_valid_q;
  logic [OpW-1:0]  s1_op_q;
  logic            s1_last_q;
  logic [PtrW-1:0] s1_slot_q;
  logic            fwd_q;
  logic [ScoreW-1:0] fwd_data_q;

  // Per-read state.
  logic [SumW-1:0] sum_q, sum_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            stopped_q, stopped_d;
  logic [PosW-1:0] cut_q, cut_d;

  logic [CmpW-1:0] thr_ext;
  logic [CntW-1:0] win;
  logic [PtrW-1:0] eff_slot;
  logic [CntW-1:0] next_cnt;
  logic [PtrW-1:0] adv_slot;
  logic            fwd_d;

  logic [ScoreW-1:0] old_score;
  logic [ScoreW-1:0] sub_score;
  logic [SumW:0]     add_sum;
  logic [SumW:0]     diff_sum;
  logic [SumW-1:0]   new_sum;
  logic              hit;
  logic [CutW-1:0]   pos_plus;
  logic [CutW-1:0]   win_ext;
  logic [CutW-1:0]   win_cut;
  logic [PosW-1:0]   cut_val;
  logic [PosW-1:0]   pos_inc;
  logic [CntW-1:0]   slot_next;
  logic              take;

  // Window length is the threshold clamped into one to the ring depth.
  assign thr_ext = CmpW'(threshold_i);
  always_comb begin
    if (thr_ext == '0) begin
      win = CntW'(1);
    end else if (thr_ext > CmpW'(RUN_DEPTH)) begin
      win = CntW'(RUN_DEPTH);
    end else begin
      win = CntW'(thr_ext);
    end
  end

  // First stage: pick the ring slot and advance the pointer on the assumption
  // that the symbol does not stop the read. After a stop the pointer no longer
  // matters until the read ends and it restarts at slot zero.
  assign eff_slot = (CntW'(ptr_q) >= win) ? '0 : ptr_q;
  assign next_cnt = CntW'(eff_slot) + CntW'(1);
  assign adv_slot = (next_cnt >= win) ? '0 : next_cnt[PtrW-1:0];
  assign ring_re  = accept_i && (req_i.opcode == OpSymbol) && successive_i;

  always_comb begin
    ptr_d = ptr_q;
    if (accept_i) begin
      case (req_i.opcode)
        OpEmpty: begin
          ptr_d = '0;
        end
        OpSymbol: begin
          if (req_i.last_symbol) begin
            ptr_d = '0;
          end else if (successive_i) begin
            ptr_d = adv_slot;
          end
        end
        default: begin
          ptr_d = ptr_q;
        end
      endcase
    end
  end

  // A slot written by the second stage in the same cycle it is read is forwarded.
  assign fwd_d = ring_re && ring_we && (s1_slot_q == eff_slot);

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem_q[s1_slot_q] <= score_i;
    end
    if (ring_re) begin
      ring_rdata_q <= ring_mem_q[eff_slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_op_q    <= req_i.opcode;
      s1_last_q  <= req_i.last_symbol;
      s1_slot_q  <= eff_slot;
      fwd_data_q <= score_i;
    end
  end

  // Second stage: score of the leaving slot, new sum and threshold compare.
  assign old_score = fwd_q ? fwd_data_q :
                     ((CntW'(s1_slot_q) < fill_q) ? ring_rdata_q : '0);
  assign sub_score = successive_i ? old_score : '0;
  assign add_sum   = {1'b0, sum_q} + (SumW + 1)'(score_i);
  assign diff_sum  = (add_sum >= (SumW + 1)'(sub_score)) ?
                     add_sum - (SumW + 1)'(sub_score) : '0;
  assign new_sum   = diff_sum[SumW] ? '1 : diff_sum[SumW-1:0];
  assign hit       = new_sum >= SumW'(threshold_i);

  // Cut point: the symbol index, or where the window began, clamped at zero.
  assign pos_plus = {1'b0, pos_q} + CutW'(1);
  assign win_ext  = CutW'(win);
  assign win_cut  = (pos_plus >= win_ext) ? pos_plus - win_ext : '0;
  assign cut_val  = successive_i ? win_cut[PosW-1:0] : pos_q;

  assign pos_inc   = (pos_q < PosW'(ReadCap)) ? pos_q + PosW'(1) : pos_q;
  assign slot_next = CntW'(s1_slot_q) + CntW'(1);
  assign take      = s1_valid_q && (s1_op_q == OpSymbol) && !stopped_q;

  always_comb begin
    sum_d       = sum_q;
    pos_d       = pos_q;
    stopped_d   = stopped_q;
    cut_d       = cut_q;
    fill_d      = fill_q;
    ring_we     = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (s1_valid_q) begin
      case (s1_op_q)
        OpEmpty: begin
          res_valid_o = 1'b1;
          sum_d       = '0;
          pos_d       = '0;
          stopped_d   = 1'b0;
          cut_d       = '0;
          fill_d      = '0;
        end
        OpSymbol: begin
          if (take) begin
            sum_d = new_sum;
            if (hit) begin
              stopped_d = 1'b1;
              cut_d     = cut_val;
            end else if (successive_i && !s1_last_q) begin
              // The ring is cleared at read end, so the last symbol needs no write.
              ring_we = 1'b1;
              if (slot_next > fill_q) begin
                fill_d = slot_next;
              end
            end
          end
          pos_d = pos_inc;
          if (s1_last_q) begin
            res_valid_o         = 1'b1;
            res_o.threshold_hit = stopped_d;
            res_o.trim_end      = stopped_d ? cut_d : pos_d;
            sum_d               = '0;
            pos_d               = '0;
            stopped_d           = 1'b0;
            cut_d               = '0;
            fill_d              = '0;
          end
        end
        default: begin
          sum_d = sum_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      fill_q     <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      sum_q      <= '0;
      pos_q      <= '0;
      stopped_q  <= 1'b0;
      cut_q      <= '0;
    end else begin
      ptr_q      <= ptr_d;
      fill_q     <= fill_d;
      s1_valid_q <= accept_i;
      fwd_q      <= fwd_d;
      sum_q      <= sum_d;
      pos_q      <= pos_d;
      stopped_q  <= stopped_d;
      cut_q      <= cut_d;
    end
  end

  // A stopped read must leave the ring untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni) stopped_q |-> !ring_we)
    else $error("ring written after the read stopped");

  // The fill count never runs past the ring depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= CntW'(RUN_DEPTH))
    else $error("ring fill count beyond ring depth");

  // An empty read always reports a zero cut without a hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (res_valid_o && (s1_op_q == OpEmpty)) |-> (res_o == '0))
    else $error("empty read gave a nonzero result");

endmodule

/* rtl/core/qttp_res_queue.sv */
// Result queue: a small register queue between the trim core and the output channel.
module qttp_res_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  qttp_pkg::qttp_out_t  data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qttp_pkg::qttp_out_t  out_o,
  output logic                room_o
);
  import qttp_pkg::*;

  localparam int unsigned IdxW = $clog2(ResQDepth);
  localparam int unsigned CntW = $clog2(ResQDepth + 1);

  qttp_out_t       mem_q [ResQDepth];
  logic [IdxW-1:0] wr_ptr_q;
  logic [IdxW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_o       = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  // A new request may enter only if the result in flight and its own still fit.
  assign room_o = cnt_q < CntW'(ResQDepth - 1);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + IdxW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + IdxW'(1);
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // The input credit check must keep the queue from overflowing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !(push_i && !pop && (cnt_q == CntW'(ResQDepth))))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(ResQDepth))
    else $error("result queue count out of range");

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the quality tail trim point unit with a built-in trim predictor.
module tb_top;
  import qttp_pkg::*;

  localparam int unsigned ClkHalf     = 6;
  localparam int unsigned RingDepth   = RunDepthDef;
  localparam int unsigned RandItems   = 1150;
  localparam int unsigned LongReadLen = 65540;
  // Results leave once their last request has passed the pipeline; leave a margin on top.
  localparam int unsigned QuietCycles = 6;
  // Watchdog limit, set well above the slowest correct run.
  localparam int unsigned CycleLimit  = 2000000;

  // Codes the block must ignore.
  localparam logic [OpW-1:0]     OpUnused  = 2'd3;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  localparam qttp_in_t  NoReq = '0;
  localparam qttp_out_t NoRes = '0;

  // One row of the directed table: a register write or a request, with an
  // optional hand-typed result for the request.
  typedef struct packed {
    bit                  cfg_write;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [ThrW-1:0]     reg_val;
    qttp_in_t            req;
    bit                  typed;
    qttp_out_t           res;
  } stim_row_t;

  localparam int unsigned DirRows = 27;
  localparam stim_row_t DirTab [DirRows] = '{
    // After reset: threshold 1, cumulative sum.
    '{1'b0, RegThreshold, 9'd0, '{OpEmpty, 8'h00, 8'h00, 1'b0}, 1'b1, '{16'd0, 1'b0}},
    '{1'b0, RegThreshold, 9'd0, '{OpUnused, 8'hFF, 8'hFF, 1'b1}, 1'b0, NoRes},
    '{1'b0, RegThreshold, 9'd0, '{OpWrite, 8'h02, 8'h03, 1'b1}, 1'b0, NoRes},
    '{1'b0, RegThreshold, 9'd0, '{OpSymbol, 8'h00, 8'h00, 1'b0}, 1'b0, NoRes},
    '{1'b0, RegThreshold, 9'd0, '{OpSymbol, 8'hFF, 8'h00, 1'b1}, 1'b1, '{16'd1, 1'b1}},
    '{1'b0, RegThreshold, 9'd0, '{OpSymbol, 8'h00, 8'hFF, 1'b1}, 1'b1, '{16'd1, 1'b0}},
    // A zero threshold is reached at the first symbol.
    '{1'b1, RegThreshold, 9'd0, NoReq, 1'b0, NoRes},
    '{1'b0, RegThreshold, 9'd0, '{OpSymbol, 8'h00, 8'h00, 1'b1}, 1'b1, '{16'd0, 1'b1}},
    // Largest threshold: a read that stays under it, then a read abandoned by an empty read.
    '{1'b1, RegThreshold, 9'd511, NoReq, 1'b0, NoRes},
    '{1'b0, RegThreshold, 9'd0, '{OpSymbol, 8'hFF, 8'h00, 1'b0}, 1'b0, NoRes},
    '{1'b0, RegThreshold, 9'd0, '{OpSymbol, 8'hFF, 8'h00, 1'b1}, 1'b1, '{16'd2, 1'b0}},
    '{1'b0, RegThreshold, 9'd0, '{OpSymbol, 8'hFF, 8'h00, 1'b0}, 1'b0, NoRes},
    '{1'b0, RegThreshold, 9'd0, '{OpSymbol, 8'h02, 8'h00, 1'b0}, 1'b0, NoRes},
    '{1'b0, RegThreshold, 9'd0, '{OpEmpty, 8'hFF, 8'hFF, 1'b1}, 1'b1, '{16'd0, 1'b0}},
    // Window sum with a short window, then a threshold beyond the ring depth, then a zero one.
    '{1'b1, RegSuccessive, 9'd1, NoReq, 1'b0, NoRes},
    '{1'b1, RegThreshold, 9'd2, NoReq, 1'b0, NoRes},
    '{1'b0, RegThreshold, 9'd0, '{OpSymbol, 8'h01, 8'h00, 1'b0}, 1'b0, NoRes},
    '{1'b0, RegThreshold, 9'd0, '{OpSymbol, 8'h01, 8'h00, 1'b0}, 1'b0, NoRes},
    '{1'b0, RegThreshold, 9'd0, '{OpSymbol, 8'hFF, 8'h00, 1'b1}, 1'b0, NoRes},
    '{1'b1, RegThreshold, 9'd300, NoReq, 1'b0, NoRes},
    '{1'b0, RegThreshold, 9'd0, '{OpSymbol, 8'hFF, 8'h00, 1'b0}, 1'b0, NoRes},
    '{1'b0, RegThreshold, 9'd0, '{OpSymbol, 8'hFF, 8'h00, 1'b1}, 1'b0, NoRes},
    '{1'b1, RegThreshold, 9'd0, NoReq, 1'b0, NoRes},
    '{1'b0, RegThreshold, 9'd0, '{OpSymbol, 8'h00, 8'h00, 1'b1}, 1'b1, '{16'd0, 1'b1}},
    // Writes to an unused index are ignored; then back to the reset setting.
    '{1'b1, RegUnused, 9'h1FF, NoReq, 1'b0, NoRes},
    '{1'b1, RegSuccessive, 9'd0, NoReq, 1'b0, NoRes},
    '{1'b1, RegThreshold, 9'd1, NoReq, 1'b0, NoRes}
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [ThrW-1:0]     cfg_data;
  logic                in_valid;
  logic                in_ready;
  qttp_in_t            in_req;
  logic                out_valid;
  logic                out_ready = 1'b0;
  qttp_out_t           out_rsp;

  // Predictor state: a copy of the registers, the score table and the read.
  logic [ThrW-1:0]     cur_thr;
  bit                  cur_succ;
  bit [ScoreW-1:0]     score_tbl [256];
  bit [ScoreW-1:0]     ring_mem [RingDepth];
  int unsigned         run_sum;
  int unsigned         sym_pos;
  int unsigned         ring_ptr;
  int unsigned         cut_pos;
  bit                  cut_found;

  qttp_out_t           pending_trims [$];
  int unsigned         err_cnt = 0;
  int unsigned         req_count = 0;
  int unsigned         cycle_cnt = 0;
  int unsigned         rx_hold = 0;
  bit                  rx_calm = 1'b0;
  bit                  tx_calm = 1'b0;

  always #(ClkHalf) clk = ~clk;

  quality_tail_trim_point_unit #(
    .RUN_DEPTH(RingDepth)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  // Clears everything that belongs to the read in progress.
  function automatic void start_read();
    foreach (ring_mem[i]) ring_mem[i] = '0;
    run_sum   = 0;
    sym_pos   = 0;
    ring_ptr  = 0;
    cut_pos   = 0;
    cut_found = 1'b0;
  endfunction

  // Adds the score of one symbol and looks for the cut point.
  function automatic void score_symbol(bit [SymW-1:0] sym);
    int unsigned m;
    int unsigned win;
    int unsigned old;
    int unsigned thr;
    thr = 32'(cur_thr);
    m   = 32'(score_tbl[sym]);
    if (!cur_succ) begin
      run_sum += m;
      if (run_sum > 65535) run_sum = 65535;
      if (run_sum >= thr) begin
        cut_found = 1'b1;
        cut_pos   = sym_pos;
      end
    end else begin
      // The window is the threshold clamped to the ring; the compare uses it raw.
      win = (thr < 1) ? 1 : ((thr > RingDepth) ? RingDepth : thr);
      if (ring_ptr >= win) ring_ptr = 0;
      old = 32'(ring_mem[ring_ptr]);
      run_sum += m;
      run_sum = (run_sum >= old) ? run_sum - old : 0;
      if (run_sum > 65535) run_sum = 65535;
      if (run_sum >= thr) begin
        cut_found = 1'b1;
        cut_pos   = (sym_pos + 1 >= win) ? sym_pos + 1 - win : 0;
      end else begin
        ring_mem[ring_ptr] = m[ScoreW-1:0];
        ring_ptr = (ring_ptr + 1 >= win) ? 0 : ring_ptr + 1;
      end
    end
  endfunction

  // Applies one request to the predictor; returns 1 when it finishes a read.
  function automatic bit predict_trim(qttp_in_t r, output qttp_out_t res);
    res = '0;
    case (r.opcode)
      OpWrite: begin
        score_tbl[r.symbol] = r.score;
        return 1'b0;
      end
      OpEmpty: begin
        start_read();
        return 1'b1;
      end
      OpSymbol: begin
        // After a hit the rest of the read is only counted.
        if (!cut_found) score_symbol(r.symbol);
        if (sym_pos < ReadCap) sym_pos++;
        if (!r.last_symbol) return 1'b0;
        res.trim_end      = cut_found ? cut_pos[PosW-1:0] : sym_pos[PosW-1:0];
        res.threshold_hit = cut_found;
        start_read();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned idle_gap(bit calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Table scores by address range: low addresses score small, high ones anything.
  function automatic bit [ScoreW-1:0] class_score(bit [SymW-1:0] e);
    if (e == 8'd0) return 8'd0;
    if (e == 8'd1) return 8'd1;
    if (e == 8'd255) return 8'd255;
    if (e < 8'd64) return ScoreW'($urandom_range(0, 3));
    if (e < 8'd128) return ScoreW'($urandom_range(0, 31));
    return ScoreW'($urandom_range(0, 255));
  endfunction

  // Sends one request and records its expected result on acceptance.
  // Entered and left at a falling edge; valid is left high for the caller.
  task automatic send_req(qttp_in_t r, bit typed, qttp_out_t typed_res);
    int unsigned gap;
    bit          done;
    qttp_out_t   res;
    gap = idle_gap(tx_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req   <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    done = predict_trim(r, res);
    if (done) pending_trims.push_back(typed ? typed_res : res);
    if (r.opcode != OpUnused) req_count++;
    @(negedge clk);
  endtask

  // Writes one register and updates the predictor's copy.
  task automatic send_cfg(logic [CfgIdxW-1:0] idx, logic [ThrW-1:0] data);
    cfg_idx   <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == RegThreshold) cur_thr = data;
    else if (idx == RegSuccessive) cur_succ = data[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stops requests and waits until every result is in and the pipeline is empty.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_trims.size() != 0) @(negedge clk);
    repeat (QuietCycles) @(negedge clk);
  endtask

  // Picks a new register setting for a phase, extremes included.
  task automatic pick_setting();
    logic [ThrW-1:0] thr;
    case ($urandom_range(0, 9))
      0:       thr = 9'd0;
      1:       thr = 9'd1;
      2:       thr = 9'd256;
      3:       thr = 9'd511;
      4:       thr = ThrW'($urandom_range(257, 511));
      5, 6:    thr = ThrW'($urandom_range(2, 16));
      default: thr = ThrW'($urandom_range(1, 255));
    endcase
    if ($urandom_range(0, 3) != 0) send_cfg(RegThreshold, thr);
    if ($urandom_range(0, 1) != 0) send_cfg(RegSuccessive, ThrW'($urandom_range(0, 511)));
    if ($urandom_range(0, 9) == 0) send_cfg(RegUnused, ThrW'($urandom_range(0, 511)));
  endtask

  // One read with random content: mostly well formed, sometimes abandoned by an
  // empty read, sometimes left open across a register change.
  task automatic issue_read(bit leave_open);
    int unsigned roll;
    int unsigned len;
    int unsigned stop_at;
    int unsigned i;
    int unsigned cls;
    qttp_in_t    r;
    roll = $urandom_range(0, 9);
    r.opcode      = OpEmpty;
    r.symbol      = SymW'($urandom_range(0, 255));
    r.score       = ScoreW'($urandom_range(0, 255));
    r.last_symbol = 1'($urandom_range(0, 1));
    if (roll == 0) begin
      send_req(r, 1'b0, NoRes);
      return;
    end
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 300) : $urandom_range(1, 16);
    stop_at = (leave_open || roll == 1) ? $urandom_range(0, len - 1) : len;
    cls = $urandom_range(0, 3);
    for (i = 0; i < stop_at; i++) begin
      // Occasional table rewrites and ignored opcodes inside the read.
      if ($urandom_range(0, 19) == 0) begin
        r.symbol      = SymW'($urandom_range(0, 255));
        r.opcode      = ($urandom_range(0, 2) == 0) ? OpUnused : OpWrite;
        r.score       = (r.opcode == OpWrite) ? class_score(r.symbol) : 8'($urandom);
        r.last_symbol = 1'($urandom_range(0, 1));
        send_req(r, 1'b0, NoRes);
      end
      r.opcode = OpSymbol;
      case (cls)
        0:       r.symbol = SymW'($urandom_range(0, 63));
        1:       r.symbol = SymW'($urandom_range(64, 127));
        2:       r.symbol = SymW'($urandom_range(128, 255));
        default: r.symbol = SymW'($urandom_range(0, 255));
      endcase
      r.score       = ScoreW'($urandom_range(0, 255));
      r.last_symbol = (i == len - 1);
      send_req(r, 1'b0, NoRes);
    end
    if (roll == 1) begin
      r.opcode = OpEmpty;
      send_req(r, 1'b0, NoRes);
    end
  endtask

  // Result receiver: random stalls with calm stretches.
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) rx_calm = ~rx_calm;
    if (rx_hold != 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!rx_calm) rx_hold = idle_gap(1'b0);
    end
  end

  // Each accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    qttp_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_trims.size() == 0) begin
        $error("unexpected result: trim_end %0d, threshold_hit %0b",
               out_rsp.trim_end, out_rsp.threshold_hit);
        err_cnt++;
      end else begin
        want = pending_trims.pop_front();
        if (out_rsp.trim_end !== want.trim_end) begin
          $error("trim_end: expected %0d, got %0d", want.trim_end, out_rsp.trim_end);
          err_cnt++;
        end
        if (out_rsp.threshold_hit !== want.threshold_hit) begin
          $error("threshold_hit: expected %0b, got %0b",
                 want.threshold_hit, out_rsp.threshold_hit);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned row;
    int unsigned n;
    int unsigned j;
    int unsigned base;
    qttp_in_t    r;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_idx   = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_req    = '0;
    cur_thr   = ThrReset;
    cur_succ  = 1'b0;
    start_read();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Load every table entry first, so no unwritten entry is ever read.
    for (row = 0; row < 256; row++) begin
      r = '{OpWrite, row[SymW-1:0], class_score(row[SymW-1:0]), 1'b0};
      send_req(r, 1'b0, NoRes);
    end

    // Directed table.
    for (row = 0; row < DirRows; row++) begin
      if (DirTab[row].cfg_write) begin
        wait_quiet();
        send_cfg(DirTab[row].reg_idx, DirTab[row].reg_val);
      end else begin
        send_req(DirTab[row].req, DirTab[row].typed, DirTab[row].res);
      end
    end

    // One read longer than the position counter: it must hold at its top value,
    // and the final high score hits there.
    wait_quiet();
    send_cfg(RegThreshold, 9'd1);
    send_cfg(RegSuccessive, 9'd0);
    tx_calm = 1'b1;
    for (j = 0; j < LongReadLen; j++) begin
      r = '{OpSymbol, 8'h00, 8'($urandom), 1'b0};
      send_req(r, 1'b0, NoRes);
    end
    r = '{OpSymbol, 8'hFF, 8'($urandom), 1'b1};
    send_req(r, 1'b0, NoRes);
    tx_calm = 1'b0;

    // Random phases, each under its own register setting.
    base = req_count;
    while (req_count - base < RandItems) begin
      wait_quiet();
      pick_setting();
      n = $urandom_range(1, 4);
      for (j = 0; j < n; j++) begin
        if ($urandom_range(0, 5) == 0) tx_calm = ~tx_calm;
        issue_read(j == n - 1 && $urandom_range(0, 2) == 0);
      end
    end

    wait_quiet();
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
